// File: rtl/core/sxe_pkg.sv
// ----------------------------------------------------------------------------
// sxe_pkg: shared types and constants of the horizontal Sobel filter
// Pixel, column and control types, register indexes and the divide by nine.
// ----------------------------------------------------------------------------
`default_nettype none

package sxe_pkg;

  localparam int unsigned PIX_W   = 24;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned WIDTH_W = 11;
  localparam int unsigned HEIGHT_W = 13;
  localparam int unsigned ROW_W   = 14;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned SUM_W   = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [CH_W-1:0]     ALPHA_OPAQUE = 8'hFF;

  // 7282 / 65536 is just above 1/9 and exact for magnitudes up to 1020.
  localparam logic [12:0] DIV9_MUL   = 13'd7282;
  localparam int unsigned DIV9_SHIFT = 16;

  typedef logic [PIX_W-1:0] pix_t;

  // One window column: top, middle and bottom row.
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  typedef logic signed [SUM_W-1:0] sum_t;

  // Control handed from the accept stage to the window stage.
  typedef struct packed {
    logic cur_ok;
    logic left_ok;
    logic top_zero;
    logic bot_zero;
    logic emit;
    logic last;
    logic fwd;
  } win_ctl_t;

  // Signed sum divided by nine, truncating toward zero, low 8 bits kept.
  function automatic logic [CH_W-1:0] div9_low8(input sum_t s);
    logic [SUM_W-2:0] mag;
    logic [22:0]      prod;
    logic [CH_W-1:0]  q;
    mag  = s[SUM_W-1] ? (SUM_W-1)'(-s) : s[SUM_W-2:0];
    prod = 23'(mag) * 23'(DIV9_MUL);
    q    = prod[DIV9_SHIFT +: CH_W];
    return s[SUM_W-1] ? CH_W'(-q) : q;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/sxe_if.sv
// ----------------------------------------------------------------------------
// sxe_in_if / sxe_out_if: pixel word channels
// Valid/ready channels carrying input pixels and filtered result pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface sxe_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, operation, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, operation, in_red, in_green, in_blue, output ready);
endinterface

interface sxe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       end_of_image;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, end_of_image,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, end_of_image,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/sobel_x_edge_filter_rgb_unit.sv
// ----------------------------------------------------------------------------
// sobel_x_edge_filter_rgb_unit: horizontal Sobel gradient on an RGB stream
// Two line stores and a chain of window column cells feed a per-channel
// gradient sum, which is divided by nine and emitted with opaque alpha.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle, sustained, while the result side takes words.
// Stages: an accepted word passes the line store read, the window and sum
// and the divide by nine on its way into the output register.
// A result belongs to the word taken one image row plus one pixel earlier.
// Reset clears counters, window cells and valid flags; line stores are not
// cleared, as border gating never uses stale entries.
`default_nettype none

module sobel_x_edge_filter_rgb_unit
  import sxe_pkg::*;
#(
  parameter int unsigned MAX_LINE_WIDTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  sxe_in_if.sink                     in_word,
  sxe_out_if.source                  out_word
);

  localparam int unsigned CW = $clog2(MAX_LINE_WIDTH);
  localparam int unsigned NCELLS = 2;

  // Configuration and position counters.
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [CW-1:0]       col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;

  logic adv, accept;

  // Accept-stage signals.
  logic [CW:0]          w_eff;
  logic [HEIGHT_W-1:0]  h_eff;
  logic [CW-1:0]        ci;
  logic                 ci_nz;
  logic signed [ROW_W:0] orow, h_s;
  logic [CW:0]          ci_inc;
  pix_t                 cur;
  win_ctl_t             ctl;

  // Window-stage registers.
  logic      s1_valid_r;
  win_ctl_t  s1_ctl_r;
  logic [CW-1:0] s1_ci_r;
  pix_t      s1_cur_r;
  pix_t      wr_up_r, wr_mid_r;
  pix_t      up_q, mid_q, up_v, mid_v;
  col_t      col_new;
  col_t      cell_out [NCELLS];
  col_t      t0, t2;
  sum_t      sum [3];

  // Sum-stage registers.
  logic      s2_valid_r, s2_last_r;
  sum_t      s2_sum_r [3];

  // Output register.
  logic       out_valid_r, out_last_r;
  logic [7:0] out_r_r, out_g_r, out_b_r;

  assign adv    = !out_valid_r || out_word.ready;
  assign accept = in_word.valid && adv;
  assign in_word.ready = adv;

  // Effective width and height.
  always_comb begin
    if (width_r == '0) begin
      w_eff = (CW+1)'(1);
    end else if ({3'b000, width_r} > 14'(MAX_LINE_WIDTH)) begin
      w_eff = (CW+1)'(MAX_LINE_WIDTH);
    end else begin
      w_eff = (CW+1)'(width_r);
    end
    h_eff = (height_r == '0) ? HEIGHT_W'(1) : height_r;
  end

  // Position of the incoming word and of the centre pixel it completes.
  always_comb begin
    ci     = ({1'b0, col_r} >= w_eff) ? '0 : col_r;
    ci_nz  = (ci != '0);
    h_s    = $signed({2'b00, h_eff});
    orow   = $signed({1'b0, row_r}) - (ci_nz ? (ROW_W+1)'(1) : (ROW_W+1)'(2));
    ctl.cur_ok   = ci_nz;
    ctl.left_ok  = ci_nz ? ({1'b0, ci} >= (CW+1)'(2)) : (w_eff >= (CW+1)'(2));
    ctl.top_zero = (orow < $signed((ROW_W+1)'(1)));
    ctl.bot_zero = (orow + $signed((ROW_W+1)'(1)) >= h_s);
    ctl.emit     = (orow >= $signed((ROW_W+1)'(0))) && (orow < h_s);
    ctl.last     = !ci_nz && (orow == h_s - $signed((ROW_W+1)'(1)));
    ctl.fwd      = s1_valid_r && (s1_ci_r == ci);
    cur = (in_word.operation || (row_r >= {1'b0, h_eff})) ? '0 :
          {in_word.in_blue, in_word.in_green, in_word.in_red};
    ci_inc = {1'b0, ci} + (CW+1)'(1);
    if (ctl.last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (ci_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = row_r + ROW_W'(1);
    end else begin
      col_nxt = ci_inc[CW-1:0];
      row_nxt = row_r;
    end
  end

  // Registers and counters; a width or height write restarts the image.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_we && (cfg_index == CFG_IDX_WIDTH || cfg_index == CFG_IDX_HEIGHT)) begin
      if (cfg_index == CFG_IDX_WIDTH) begin
        width_r <= cfg_data[WIDTH_W-1:0];
      end else begin
        height_r <= cfg_data;
      end
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Accept stage into window stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r <= ctl;
      s1_ci_r  <= ci;
      s1_cur_r <= cur;
    end
  end

  // Line stores: upper takes the old middle entry, middle takes the new pixel.
  sxe_line_store #(.DEPTH(MAX_LINE_WIDTH), .AW(CW)) u_upper (
    .clk     (clk),
    .wr_en   (adv && s1_valid_r),
    .wr_addr (s1_ci_r),
    .wr_data (mid_v),
    .rd_en   (accept),
    .rd_addr (ci),
    .rd_data (up_q)
  );

  sxe_line_store #(.DEPTH(MAX_LINE_WIDTH), .AW(CW)) u_middle (
    .clk     (clk),
    .wr_en   (adv && s1_valid_r),
    .wr_addr (s1_ci_r),
    .wr_data (s1_cur_r),
    .rd_en   (accept),
    .rd_addr (ci),
    .rd_data (mid_q)
  );

  // The entry written while this word's read went out is taken from here.
  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      wr_up_r  <= mid_v;
      wr_mid_r <= s1_cur_r;
    end
  end

  assign up_v  = s1_ctl_r.fwd ? wr_up_r  : up_q;
  assign mid_v = s1_ctl_r.fwd ? wr_mid_r : mid_q;
  assign col_new = '{top: up_v, mid: mid_v, bot: s1_cur_r};

  // Chain of window cells: newest column first.
  for (genvar g = 0; g < NCELLS; g++) begin : g_cell
    sxe_win_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (adv && s1_valid_r),
      .col_in   ((g == 0) ? col_new : cell_out[(g == 0) ? 0 : g-1]),
      .col_out  (cell_out[g])
    );
  end

  // Taps of the outer columns; the centre column has zero weight.
  always_comb begin
    t0 = s1_ctl_r.left_ok ? cell_out[NCELLS-1] : '0;
    t2 = s1_ctl_r.cur_ok  ? col_new : '0;
    if (s1_ctl_r.top_zero) begin
      t0.top = '0;
      t2.top = '0;
    end
    if (s1_ctl_r.bot_zero) begin
      t0.bot = '0;
      t2.bot = '0;
    end
    for (int k = 0; k < 3; k++) begin
      sum[k] = sum_t'({3'b000, t0.top[8*k +: 8]}) - sum_t'({3'b000, t2.top[8*k +: 8]})
             + sum_t'({2'b00, t0.mid[8*k +: 8], 1'b0})
             - sum_t'({2'b00, t2.mid[8*k +: 8], 1'b0})
             + sum_t'({3'b000, t0.bot[8*k +: 8]}) - sum_t'({3'b000, t2.bot[8*k +: 8]});
    end
  end

  // Window stage into sum stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r && s1_ctl_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_last_r <= s1_ctl_r.last;
      for (int k = 0; k < 3; k++) begin
        s2_sum_r[k] <= sum[k];
      end
    end
  end

  // Divide by nine into the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_last_r <= s2_last_r;
      out_r_r    <= div9_low8(s2_sum_r[0]);
      out_g_r    <= div9_low8(s2_sum_r[1]);
      out_b_r    <= div9_low8(s2_sum_r[2]);
    end
  end

  assign out_word.valid        = out_valid_r;
  assign out_word.out_red      = out_r_r;
  assign out_word.out_green    = out_g_r;
  assign out_word.out_blue     = out_b_r;
  assign out_word.out_alpha    = ALPHA_OPAQUE;
  assign out_word.end_of_image = out_last_r;

  // A width or height register write restarts the image at the first pixel.
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == CFG_IDX_WIDTH || cfg_index == CFG_IDX_HEIGHT))
    |=> (col_r == '0 && row_r == '0))
    else $error("counters not cleared by register write");

  // The last pixel of an image returns the counters to the image start.
  a_last_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ctl.last && !cfg_we) |=> (col_r == '0 && row_r == '0))
    else $error("counters not wrapped after last pixel");

  // A stalled result leaves the pipeline frozen.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word.ready) |=> ($stable(s2_valid_r) && $stable(s1_valid_r)))
    else $error("pipeline moved under a stalled result");

  // The column counter stays inside the line store.
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, col_r} < (CW+1)'(MAX_LINE_WIDTH)))
    else $error("column counter out of range");

endmodule

`default_nettype wire

// File: rtl/core/sxe_line_store.sv
// ----------------------------------------------------------------------------
// sxe_line_store: one line of pixels
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sxe_line_store
  import sxe_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire pix_t          wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output pix_t               rd_data
);

  pix_t mem [DEPTH];
  pix_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/core/sxe_win_cell.sv
// ----------------------------------------------------------------------------
// sxe_win_cell: one column of the 3x3 window
// Holds a column of three pixels and hands it on to its neighbour each step.
// ----------------------------------------------------------------------------
`default_nettype none

module sxe_win_cell
  import sxe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic shift_en,
  input  wire col_t col_in,
  output col_t      col_out
);

  col_t col_r;

  // Take the neighbour's column on every window step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

endmodule

`default_nettype wire

// File: verif/tb_sobel_x_edge_filter_rgb_unit.sv
// ----------------------------------------------------------------------------
// tb_sobel_x_edge_filter_rgb_unit: self-checking bench of the Sobel X filter
// A directed table of words, then randomised images, noise and aborted images
// at many register settings. Every word taken is run through a local filter
// model and each result word is compared field by field with the oldest
// expected pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sobel_x_edge_filter_rgb_unit;
  import sxe_pkg::*;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;
  localparam int LINE_MAX    = 1024;
  localparam int SETTLE_CYC  = 8;
  localparam int RANDOM_WORDS = 450;
  localparam int WIDE_WORDS   = LINE_MAX + 160;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       eoi;
  } pixel_res_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  op;
    logic [7:0]            r, g, b;
    bit                    typed;
    pixel_res_t            res;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sxe_in_if  in_ch ();
  sxe_out_if out_ch ();

  sobel_x_edge_filter_rgb_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_word  (in_ch),
    .out_word (out_ch)
  );

  // Local copy of the filter state.
  int unsigned mdl_width;
  int unsigned mdl_height;
  pix_t        upper_line [LINE_MAX];
  pix_t        middle_line[LINE_MAX];
  pix_t        win[3][3];
  int          col_pos;
  int          row_pos;

  pixel_res_t  pending_pixels[$];
  int          mismatches = 0;
  bit          calm;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit on the run.
  initial begin
    #(12 * 1000000);
    $display("tb_sobel_x_edge_filter_rgb_unit failed");
    $finish;
  end

  function automatic int unsigned used_width();
    if (mdl_width == 0) return 1;
    if (mdl_width > LINE_MAX) return LINE_MAX;
    return mdl_width;
  endfunction

  function automatic int unsigned used_height();
    return (mdl_height == 0) ? 1 : mdl_height;
  endfunction

  function automatic void clear_filter_state();
    mdl_width  = WIDTH_RESET;
    mdl_height = HEIGHT_RESET;
    for (int i = 0; i < LINE_MAX; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++) win[c][r] = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  // A register write aborts the image in progress; other indexes are ignored.
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_IDX_WIDTH) mdl_width = data[WIDTH_W-1:0];
    else if (idx == CFG_IDX_HEIGHT) mdl_height = data[HEIGHT_W-1:0];
    else return;
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Advances the filter by one word and gives the result pixel, if any.
  function automatic void filter_step(input logic op, input logic [7:0] r, g, b,
                                      output bit emit, output pixel_res_t res);
    int   w, h, ci, ri, orow, ocol, s;
    pix_t cur;
    pix_t cn[3];
    pix_t tp[3][3];
    bit   left_ok, last;
    logic [7:0] ch_out[3];
    w = used_width();
    h = used_height();
    ci = (col_pos >= w) ? 0 : col_pos;
    ri = row_pos;
    cur = '0;
    if (op == OP_PIXEL && ri < h) cur = {b, g, r};
    cn[0] = upper_line[ci];
    cn[1] = middle_line[ci];
    cn[2] = cur;
    upper_line[ci]  = cn[1];
    middle_line[ci] = cur;
    if (ci >= 1) begin
      orow = ri - 1;
      ocol = ci - 1;
      left_ok = (ci >= 2);
    end else begin
      orow = ri - 2;
      ocol = w - 1;
      left_ok = (w >= 2);
    end
    for (int k = 0; k < 3; k++) begin
      tp[k][0] = left_ok ? win[1][k] : '0;
      tp[k][1] = win[2][k];
      tp[k][2] = (ci >= 1) ? cn[k] : '0;
    end
    // Rows above and below the image read as zero.
    if (orow < 1) for (int c = 0; c < 3; c++) tp[0][c] = '0;
    if (orow + 1 >= h) for (int c = 0; c < 3; c++) tp[2][c] = '0;
    for (int k = 0; k < 3; k++) begin
      win[0][k] = win[1][k];
      win[1][k] = win[2][k];
      win[2][k] = cn[k];
    end
    emit = (orow >= 0) && (orow < h);
    last = emit && (orow == h - 1) && (ocol == w - 1);
    for (int ch = 0; ch < 3; ch++) begin
      s = int'(tp[0][0][8*ch +: 8]) - int'(tp[0][2][8*ch +: 8])
        + 2 * (int'(tp[1][0][8*ch +: 8]) - int'(tp[1][2][8*ch +: 8]))
        + int'(tp[2][0][8*ch +: 8]) - int'(tp[2][2][8*ch +: 8]);
      s = s / 9;
      ch_out[ch] = s[7:0];
    end
    res.red   = ch_out[0];
    res.green = ch_out[1];
    res.blue  = ch_out[2];
    res.alpha = ALPHA_OPAQUE;
    res.eoi   = last;
    ci++;
    if (ci >= w) begin
      ci = 0;
      ri++;
    end
    if (last) begin
      ci = 0;
      ri = 0;
    end
    col_pos = ci;
    row_pos = ri;
  endfunction

  // Offers one word, waits for it to be taken and records its result.
  task automatic send_word(input logic op, input logic [7:0] r, g, b,
                           input bit typed = 0, input pixel_res_t typed_res = '{default: 0});
    bit         emit;
    pixel_res_t res;
    while (!calm && $urandom_range(99) < 24) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.in_red    <= r;
    in_ch.in_green  <= g;
    in_ch.in_blue   <= b;
    do @(posedge clk); while (!in_ch.ready);
    filter_step(op, r, g, b, emit, res);
    if (emit) pending_pixels.push_back(typed ? typed_res : res);
  endtask

  // Stops sending and lets every outstanding result drain.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One phase: full images back to back, or an image cut short.
  task automatic run_phase(input logic [CFG_DATA_W-1:0] wdata,
                           input logic [CFG_DATA_W-1:0] hdata,
                           input int words, output int sent);
    int unsigned w, area, span;
    logic op;
    write_reg(CFG_IDX_WIDTH, wdata);
    write_reg(CFG_IDX_HEIGHT, hdata);
    w    = used_width();
    area = w * used_height();
    span = area + w + 1;
    for (int k = 0; k < words; k++) begin
      if ((k % span) < area) op = ($urandom_range(19) == 0) ? OP_FLUSH : OP_PIXEL;
      else op = 1'($urandom_range(1));
      send_word(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
    end
    sent = words;
  endtask

  // Result side: random stalls and the check against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_pixels.size() == 0) begin
          $error("result word with no expected pixel");
          mismatches++;
        end else begin
          pixel_res_t exp_px;
          exp_px = pending_pixels.pop_front();
          if (out_ch.out_red !== exp_px.red) begin
            $error("out_red: expected %0d, got %0d", exp_px.red, out_ch.out_red);
            mismatches++;
          end
          if (out_ch.out_green !== exp_px.green) begin
            $error("out_green: expected %0d, got %0d", exp_px.green, out_ch.out_green);
            mismatches++;
          end
          if (out_ch.out_blue !== exp_px.blue) begin
            $error("out_blue: expected %0d, got %0d", exp_px.blue, out_ch.out_blue);
            mismatches++;
          end
          if (out_ch.out_alpha !== exp_px.alpha) begin
            $error("out_alpha: expected %0d, got %0d", exp_px.alpha, out_ch.out_alpha);
            mismatches++;
          end
          if (out_ch.end_of_image !== exp_px.eoi) begin
            $error("end_of_image: expected %0d, got %0d", exp_px.eoi,
                   out_ch.end_of_image);
            mismatches++;
          end
        end
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 24);
    end
  end

  // Stimulus.
  initial begin
    dir_row_t   dir_rows[$];
    int         total, sent, words, mode;
    logic [CFG_DATA_W-1:0] wdata, hdata;

    calm       = 0;
    clear_filter_state();
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_PIXEL;
    in_ch.in_red    <= '0;
    in_ch.in_green  <= '0;
    in_ch.in_blue   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Words at the reset size give no result yet.
    dir_rows.push_back('{ROW_WORD, 0, 0, OP_PIXEL, 8'hFF, 8'h00, 8'hFF, 0, '{default: 0}});
    dir_rows.push_back('{ROW_WORD, 0, 0, OP_FLUSH, 8'h00, 8'hFF, 8'h00, 0, '{default: 0}});
    // Unused register indexes change nothing.
    dir_rows.push_back('{ROW_REG, CFG_IDX_SPARE_LO, 13'h1FFF, 0, 0, 0, 0, 0, '{default: 0}});
    dir_rows.push_back('{ROW_REG, CFG_IDX_SPARE_HI, 13'h0003, 0, 0, 0, 0, 0, '{default: 0}});
    // A one pixel image: every neighbour is outside, so the result is zero.
    dir_rows.push_back('{ROW_REG, CFG_IDX_WIDTH, 13'd1, 0, 0, 0, 0, 0, '{default: 0}});
    dir_rows.push_back('{ROW_REG, CFG_IDX_HEIGHT, 13'd1, 0, 0, 0, 0, 0, '{default: 0}});
    dir_rows.push_back('{ROW_WORD, 0, 0, OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 0, '{default: 0}});
    dir_rows.push_back('{ROW_WORD, 0, 0, OP_FLUSH, 8'h00, 8'h00, 8'h00, 0, '{default: 0}});
    dir_rows.push_back('{ROW_WORD, 0, 0, OP_FLUSH, 8'h00, 8'h00, 8'h00, 1,
                         '{8'd0, 8'd0, 8'd0, 8'hFF, 1'b1}});
    // A white 3x1 row: left edge -56 (as 200), right +56; drain pixels are ignored.
    dir_rows.push_back('{ROW_REG, CFG_IDX_WIDTH, 13'd3, 0, 0, 0, 0, 0, '{default: 0}});
    for (int i = 0; i < 3; i++)
      dir_rows.push_back('{ROW_WORD, 0, 0, OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 0, '{default: 0}});
    dir_rows.push_back('{ROW_WORD, 0, 0, OP_FLUSH, 8'h00, 8'h00, 8'h00, 0, '{default: 0}});
    dir_rows.push_back('{ROW_WORD, 0, 0, OP_PIXEL, 8'h12, 8'h34, 8'h56, 1,
                         '{8'd200, 8'd200, 8'd200, 8'hFF, 1'b0}});
    dir_rows.push_back('{ROW_WORD, 0, 0, OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1,
                         '{8'd0, 8'd0, 8'd0, 8'hFF, 1'b0}});
    dir_rows.push_back('{ROW_WORD, 0, 0, OP_FLUSH, 8'hAA, 8'h55, 8'hAA, 1,
                         '{8'd56, 8'd56, 8'd56, 8'hFF, 1'b1}});
    // A 3x2 image with an early flush in the middle of it.
    dir_rows.push_back('{ROW_REG, CFG_IDX_HEIGHT, 13'd2, 0, 0, 0, 0, 0, '{default: 0}});
    dir_rows.push_back('{ROW_WORD, 0, 0, OP_PIXEL, 8'h00, 8'hFF, 8'h80, 0, '{default: 0}});
    dir_rows.push_back('{ROW_WORD, 0, 0, OP_PIXEL, 8'hFF, 8'h00, 8'h7F, 0, '{default: 0}});
    dir_rows.push_back('{ROW_WORD, 0, 0, OP_FLUSH, 8'hFF, 8'hFF, 8'hFF, 0, '{default: 0}});
    dir_rows.push_back('{ROW_WORD, 0, 0, OP_PIXEL, 8'h01, 8'hFE, 8'hFF, 0, '{default: 0}});
    dir_rows.push_back('{ROW_WORD, 0, 0, OP_PIXEL, 8'hFF, 8'h01, 8'h00, 0, '{default: 0}});
    dir_rows.push_back('{ROW_WORD, 0, 0, OP_PIXEL, 8'h00, 8'h00, 8'hFF, 0, '{default: 0}});
    for (int i = 0; i < 4; i++)
      dir_rows.push_back('{ROW_WORD, 0, 0, OP_FLUSH, 8'h00, 8'h00, 8'h00, 0, '{default: 0}});

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) write_reg(dir_rows[i].idx, dir_rows[i].data);
      else send_word(dir_rows[i].op, dir_rows[i].r, dir_rows[i].g, dir_rows[i].b,
                     dir_rows[i].typed, dir_rows[i].res);
    end

    // Widest line, cut short once the first results of its row have come,
    // with no stalls on either side.
    calm = 1;
    run_phase(13'd1024, 13'd1, WIDE_WORDS, sent);
    calm = 0;

    // Random phases: mostly whole small images, some noise and cut images.
    total = 0;
    while (total < RANDOM_WORDS) begin
      mode = $urandom_range(9);
      wdata = 13'($urandom_range(13'h1FFF));
      hdata = 13'($urandom_range(13'h1FFF));
      if (mode == 0) begin
        // Extreme or oversized registers; the image is mostly cut short.
        case ($urandom_range(3))
          0: wdata[WIDTH_W-1:0] = 11'd0;
          1: wdata[WIDTH_W-1:0] = 11'd1024;
          2: wdata[WIDTH_W-1:0] = 11'd2047;
          default: ;
        endcase
        case ($urandom_range(3))
          0: hdata = 13'd0;
          1: hdata = 13'd4096;
          2: hdata = 13'd8191;
          default: ;
        endcase
        words = $urandom_range(5, 60);
      end else begin
        wdata[WIDTH_W-1:0] = 11'($urandom_range(8));
        hdata = 13'($urandom_range(6));
        if (mode == 1) begin
          words = $urandom_range(1, 30);
        end else begin
          words = ((wdata[WIDTH_W-1:0] == 0) ? 1 : wdata[WIDTH_W-1:0]);
          words = words * ((hdata == 0) ? 1 : hdata) + words + 1;
          words = words * $urandom_range(1, 2);
        end
      end
      run_phase(wdata, hdata, words, sent);
      total += sent;
    end

    settle();
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("tb_sobel_x_edge_filter_rgb_unit passed");
    end else begin
      $display("tb_sobel_x_edge_filter_rgb_unit failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
